/* design/sbdd_pkg.sv */
// shared types, constants and helper functions for the sortable decimal decoder
package sbdd_pkg;

    // format limits
    localparam int unsigned PRECISION_MAX   = 65;
    localparam int unsigned DIGITS_PER_WORD = 9;
    localparam logic [31:0] WORD_MAX        = 32'd999_999_999;

    // field widths
    localparam int unsigned DIG_W    = 7;
    localparam int unsigned WORD_W   = 30;
    localparam int unsigned POS_W    = 6;
    localparam int unsigned ACC_W    = 32;
    localparam int unsigned GSEEN_W  = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // port packing
    localparam int unsigned M_TDATA_W = 48;
    localparam int unsigned M_TUSER_W = 2;

    // result queue
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRECISION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 2'd1;

    // reset values of the registers
    localparam logic [DIG_W-1:0] PRECISION_RST = 7'd10;
    localparam logic [DIG_W-1:0] SCALE_RST     = 7'd0;

    typedef enum logic [1:0] {
        KIND_INT     = 2'd0,
        KIND_FRAC    = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD      = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // one queue entry: an optional word, then an optional summary
    typedef struct packed {
        logic              has_word;
        kind_t             word_kind;
        logic [WORD_W-1:0] word_value;
        logic              has_sum;
        logic              sum_neg;
        logic [DIG_W-1:0]  sum_int;
        logic [DIG_W-1:0]  sum_frac;
        status_t           sum_status;
    } entry_t;

    // push side of the queue
    typedef struct packed {
        logic   push;
        entry_t entry;
    } push_t;

    // queue status seen by the input handshake and the back
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // x / 9 for x below 128, by reciprocal multiply
    function automatic logic [3:0] div9(input logic [DIG_W-1:0] x);
        logic [12:0] p;
        p = 13'(x) * 13'd57;
        return p[12:9];
    endfunction

    // bytes used by a group of n digits
    function automatic logic [2:0] bytes_for_digits(input logic [3:0] n);
        logic [2:0] r;
        case (n)
            4'd0:             r = 3'd0;
            4'd1, 4'd2:       r = 3'd1;
            4'd3, 4'd4:       r = 3'd2;
            4'd5, 4'd6:       r = 3'd3;
            default:          r = 3'd4;
        endcase
        return r;
    endfunction

    // largest value of a group of n digits
    function automatic logic [WORD_W-1:0] pow_ten_m1(input logic [3:0] n);
        logic [WORD_W-1:0] r;
        case (n)
            4'd0:    r = 30'd0;
            4'd1:    r = 30'd9;
            4'd2:    r = 30'd99;
            4'd3:    r = 30'd999;
            4'd4:    r = 30'd9999;
            4'd5:    r = 30'd99999;
            4'd6:    r = 30'd999999;
            4'd7:    r = 30'd9999999;
            4'd8:    r = 30'd99999999;
            default: r = 30'd999999999;
        endcase
        return r;
    endfunction

endpackage

/* design/sbdd_front.sv */
// front end: holds the format registers, assembles groups and classifies each byte
module sbdd_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sbdd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbdd_pkg::DIG_W-1:0]     cfg_data,
    input  logic                           accept,
    input  logic [7:0]                     data_byte,
    output sbdd_pkg::push_t                push_out
);
    import sbdd_pkg::*;

    // format registers
    logic [DIG_W-1:0] precision_reg, scale_reg;

    // record state
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [GSEEN_W-1:0] gseen_reg, gseen_next;
    logic               inv_reg, inv_next;
    logic               nzs_reg, nzs_next;
    logic [DIG_W-1:0]   idig_reg, idig_next;
    logic [DIG_W-1:0]   fdig_reg, fdig_next;
    logic               swallow_reg, swallow_next;

    // layout derived from the format
    logic             cfg_bad, cfg_ovf;
    logic [DIG_W-1:0] intg, ip_full, fp_full;
    logic [3:0]       iw, fw, ip, fp;
    logic [POS_W-1:0] b1, b2, b3, total;

    // per-byte decode
    logic               first;
    logic               inv_b, nzs_b, swallow_b;
    logic [ACC_W-1:0]   acc_b, acc_new;
    logic [GSEEN_W-1:0] gseen_b, gseen_new;
    logic [DIG_W-1:0]   idig_b, fdig_b;
    logic [7:0]         v;
    kind_t              g_kind;
    logic               g_partial;
    logic [3:0]         g_n;
    logic [2:0]         g_len;
    logic [ACC_W-1:0]   limit;
    logic               complete, bad, emit_word, rec_end;
    logic [POS_W-1:0]   pos_inc;
    entry_t             ent;

    // record layout
    always_comb
    begin
        cfg_bad = scale_reg > precision_reg;
        cfg_ovf = precision_reg > DIG_W'(PRECISION_MAX);
        intg    = precision_reg - scale_reg;
        iw      = div9(intg);
        ip_full = intg - {iw, 3'b000} - {3'b000, iw};
        ip      = ip_full[3:0];
        fw      = div9(scale_reg);
        fp_full = scale_reg - {fw, 3'b000} - {3'b000, fw};
        fp      = fp_full[3:0];
        b1      = POS_W'(bytes_for_digits(ip));
        b2      = b1 + {iw, 2'b00};
        b3      = b2 + {fw, 2'b00};
        total   = b3 + POS_W'(bytes_for_digits(fp));
    end

    // byte decode and state update
    always_comb
    begin
        first     = pos_reg == '0;
        inv_b     = first ? ~data_byte[7] : inv_reg;
        nzs_b     = first ? 1'b0 : nzs_reg;
        swallow_b = first ? 1'b0 : swallow_reg;
        acc_b     = first ? '0 : acc_reg;
        gseen_b   = first ? '0 : gseen_reg;
        idig_b    = first ? intg : idig_reg;
        fdig_b    = first ? scale_reg : fdig_reg;

        v         = data_byte ^ {8{inv_b}} ^ {first, 7'd0};
        acc_new   = {acc_b[ACC_W-9:0], v};
        gseen_new = gseen_b + GSEEN_W'(1);

        // which group this byte falls in
        if (pos_reg < b1)
        begin
            g_kind = KIND_INT;  g_partial = 1'b1; g_n = ip;   g_len = bytes_for_digits(ip);
        end
        else if (pos_reg < b2)
        begin
            g_kind = KIND_INT;  g_partial = 1'b0; g_n = 4'd9; g_len = 3'd4;
        end
        else if (pos_reg < b3)
        begin
            g_kind = KIND_FRAC; g_partial = 1'b0; g_n = 4'd9; g_len = 3'd4;
        end
        else
        begin
            g_kind = KIND_FRAC; g_partial = 1'b1; g_n = fp;   g_len = bytes_for_digits(fp);
        end

        limit     = g_partial ? ACC_W'(pow_ten_m1(g_n)) : WORD_MAX;
        complete  = !swallow_b && (gseen_new >= g_len);
        bad       = complete && (acc_new > limit);
        emit_word = 1'b0;

        pos_inc      = pos_reg + POS_W'(1);
        rec_end      = pos_inc >= total;
        inv_next     = inv_b;
        nzs_next     = nzs_b;
        idig_next    = idig_b;
        fdig_next    = fdig_b;
        acc_next     = acc_b;
        gseen_next   = gseen_b;
        swallow_next = swallow_b | bad;

        if (!swallow_b)
        begin
            acc_next   = acc_new;
            gseen_next = gseen_new;
        end

        // group finished: clear the group, and use the value only when in range
        if (complete)
        begin
            acc_next   = '0;
            gseen_next = '0;
            if (!bad)
            begin
                if (g_kind == KIND_INT)
                begin
                    if (acc_new != '0 || nzs_b)
                    begin
                        nzs_next  = 1'b1;
                        emit_word = 1'b1;
                    end
                    else
                        idig_next = idig_b - DIG_W'(g_n);
                end
                else
                begin
                    if (!g_partial || acc_new != '0)
                        emit_word = 1'b1;
                    else
                        fdig_next = fdig_b - DIG_W'(g_n);
                end
            end
        end

        pos_next = rec_end ? '0 : pos_inc;

        ent            = '0;
        ent.word_kind  = g_kind;
        ent.word_value = acc_new[WORD_W-1:0];
        ent.sum_status = ST_OK;

        if (cfg_bad || cfg_ovf || total == '0)
        begin
            // one summary per byte, record dropped
            pos_next       = '0;
            ent.has_sum    = 1'b1;
            ent.sum_status = cfg_bad ? ST_BAD : (cfg_ovf ? ST_OVERFLOW : ST_OK);
        end
        else if (bad)
        begin
            ent.has_sum    = 1'b1;
            ent.sum_status = ST_BAD;
        end
        else
        begin
            ent.has_word = emit_word;
            if (rec_end && !swallow_b)
            begin
                ent.has_sum  = 1'b1;
                ent.sum_neg  = inv_b && !(idig_next == '0 && fdig_next == '0);
                ent.sum_int  = idig_next;
                ent.sum_frac = fdig_next;
            end
        end

        push_out.push  = accept && (ent.has_word || ent.has_sum);
        push_out.entry = ent;
    end

    // format registers and record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            precision_reg <= PRECISION_RST;
            scale_reg     <= SCALE_RST;
            pos_reg       <= '0;
            acc_reg       <= '0;
            gseen_reg     <= '0;
            inv_reg       <= 1'b0;
            nzs_reg       <= 1'b0;
            idig_reg      <= '0;
            fdig_reg      <= '0;
            swallow_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            // a write to either format register abandons the record in progress
            if (cfg_index == REG_PRECISION)
            begin
                precision_reg <= cfg_data;
                pos_reg       <= '0;
            end
            else if (cfg_index == REG_SCALE)
            begin
                scale_reg <= cfg_data;
                pos_reg   <= '0;
            end
        end
        else if (accept)
        begin
            pos_reg     <= pos_next;
            acc_reg     <= acc_next;
            gseen_reg   <= gseen_next;
            inv_reg     <= inv_next;
            nzs_reg     <= nzs_next;
            idig_reg    <= idig_next;
            fdig_reg    <= fdig_next;
            swallow_reg <= swallow_next;
        end
    end

endmodule

/* design/sbdd_queue.sv */
// short queue of classified entries between front and back
module sbdd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sbdd_pkg::push_t      push_in,
    input  logic                 pop,
    output sbdd_pkg::entry_t     head,
    output sbdd_pkg::q_status_t  status
);
    import sbdd_pkg::*;

    entry_t             entry_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
    endfunction

    // pointer and fill count
    always_comb
    begin
        status.empty = count_reg == '0;
        status.full  = count_reg == Q_CNT_W'(Q_DEPTH);
        do_push      = push_in.push && !status.full;
        do_pop       = pop && !status.empty;
        wr_ptr_next  = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next  = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next   = count_reg + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
        head         = entry_q[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_q[wr_ptr_reg] <= push_in.entry;
    end

endmodule

/* design/sbdd_back.sv */
// back end: expands queue entries into result transfers through an output register
module sbdd_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sbdd_pkg::entry_t                 head,
    input  sbdd_pkg::q_status_t              q_status,
    output logic                             pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sbdd_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [sbdd_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                             m_tlast
);
    import sbdd_pkg::*;

    logic              out_valid_reg, out_valid_next;
    logic              phase_reg, phase_next;
    kind_t             kind_reg;
    logic [WORD_W-1:0] word_reg;
    logic              neg_reg;
    logic [DIG_W-1:0]  idig_reg, fdig_reg;
    status_t           status_reg;
    logic              last_reg;
    logic              load, sel_word;

    // pick the word first, then the summary of the same entry
    always_comb
    begin
        load           = !q_status.empty && (!out_valid_reg || m_tready);
        sel_word       = head.has_word && !phase_reg;
        pop            = load && !(sel_word && head.has_sum);
        phase_next     = load ? (sel_word && head.has_sum) : phase_reg;
        out_valid_next = load ? 1'b1 : (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (sel_word)
            begin
                kind_reg   <= head.word_kind;
                word_reg   <= head.word_value;
                neg_reg    <= 1'b0;
                idig_reg   <= '0;
                fdig_reg   <= '0;
                status_reg <= ST_OK;
                last_reg   <= 1'b0;
            end
            else
            begin
                kind_reg   <= KIND_SUMMARY;
                word_reg   <= '0;
                neg_reg    <= head.sum_neg;
                idig_reg   <= head.sum_int;
                fdig_reg   <= head.sum_frac;
                status_reg <= head.sum_status;
                last_reg   <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, status_reg, fdig_reg, idig_reg, neg_reg, word_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

/* design/sortable_binary_decimal_decoder.sv */
// top level of the sortable packed decimal decoder
// Decodes one memcmp-sortable packed decimal record, one byte per transfer on the s_ side,
// into base-billion words and a closing summary on the m_ side. The record layout follows
// the precision and scale registers; writing either one drops any record in progress. The
// block takes one byte every cycle while the queue has room: the front end assembles and
// checks a group in the cycle the byte is taken and pushes what it produces into a four-entry
// queue, and the back end sends one result per cycle while m_tready is high, from its output
// register. A byte that closes both a group and the record yields two results, a word and
// then a summary; the queue absorbs this and input stalls only when it fills.
// There is no clearing pass after reset.
module sortable_binary_decimal_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [sbdd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbdd_pkg::DIG_W-1:0]     cfg_data,
    // byte input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // data_byte
    // result output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // word_value[29:0], is_negative[30], int_digits[37:31], frac_digits[44:38],
    // status[46:45], zero pad[47]
    output logic [sbdd_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [sbdd_pkg::M_TUSER_W-1:0] m_tuser,   // item_kind[1:0]
    output logic                           m_tlast    // last
);
    import sbdd_pkg::*;

    push_t     push;
    entry_t    head;
    q_status_t q_status;
    logic      pop;
    logic      accept;

    // input transfer
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    sbdd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .data_byte (s_tdata),
        .push_out  (push)
    );

    sbdd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (push),
        .pop     (pop),
        .head    (head),
        .status  (q_status)
    );

    sbdd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // only summaries close a value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == KIND_SUMMARY)))
        else $error("last flag does not match result kind");

    // words carry no status and stay within one base-billion digit group
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != KIND_SUMMARY) |->
            (m_tdata[46:45] == ST_OK && m_tdata[29:0] <= WORD_MAX[29:0]))
        else $error("word result out of range");

    // error summaries carry no sign and no digit counts
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_SUMMARY && m_tdata[46:45] != ST_OK) |->
            (m_tdata[44:30] == '0))
        else $error("error summary carries value fields");

    // no byte is taken while the queue is full
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !accept)
        else $error("byte taken while queue full");

endmodule
